// File: rtl/matrix_scanned_quadrature_encoders_core_macros.svh
// assertion macros for the matrix scanned quadrature encoder core
// used by files that check their own logic; no other dependencies
`ifndef MATRIX_SCANNED_QUADRATURE_ENCODERS_CORE_MACROS_SVH
`define MATRIX_SCANNED_QUADRATURE_ENCODERS_CORE_MACROS_SVH
`ifndef SYNTH
`define MSQE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("msqe check failed");
`define MSQE_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("msqe reset check failed");
`else
`define MSQE_ASSERT(label, prop)
`define MSQE_ASSERT_RST(label, prop)
`endif
`endif

// File: rtl/msqe_pkg.sv
// constants and types for the matrix scanned quadrature encoder core
// no dependencies
package msqe_pkg;

  localparam int ROWS           = 6;
  localparam int COLUMNS        = 4;
  localparam int COUNT_BITS     = 16;
  localparam int ROWS_PER_GROUP = 3;
  localparam int GROUPS         = ROWS / ROWS_PER_GROUP;
  localparam int ENCODERS       = GROUPS * COLUMNS;

  localparam int COL_BITS = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int GRP_BITS = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int ENC_BITS = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;

  localparam int ROW_FIELD_BITS    = 6;
  localparam int COLUMN_FIELD_BITS = 2;
  localparam int INDEX_FIELD_BITS  = 3;
  localparam int COUNT_FIELD_BITS  = 16;

  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic [COLUMN_FIELD_BITS-1:0]       column;
    logic [INDEX_FIELD_BITS-1:0]        encoder_index;
    logic signed [COUNT_FIELD_BITS-1:0] count;
    logic                               pressed;
    logic                               last;
  } result_t;

endpackage

// File: rtl/msqe_stream_if.sv
// valid/ready channels for scanned row levels and per-encoder results
// depends on msqe_pkg
interface msqe_item_if;
  logic                                     valid;
  logic                                     ready;
  logic [msqe_pkg::ROW_FIELD_BITS-1:0]      row_levels;

  modport source (output valid, output row_levels, input ready);
  modport sink (input valid, input row_levels, output ready);
endinterface

interface msqe_result_if;
  logic                                        valid;
  logic                                        ready;
  logic [msqe_pkg::COLUMN_FIELD_BITS-1:0]      column;
  logic [msqe_pkg::INDEX_FIELD_BITS-1:0]       encoder_index;
  logic signed [msqe_pkg::COUNT_FIELD_BITS-1:0] count;
  logic                                        pressed;
  logic                                        last;

  modport source (output valid, output column, output encoder_index, output count,
                  output pressed, output last, input ready);
  modport sink (input valid, input column, input encoder_index, input count,
                input pressed, input last, output ready);
endinterface

// File: rtl/msqe_ram.sv
// generic single write port ram with one registered read port
// no dependencies; read during write returns the old data
module msqe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/matrix_scanned_quadrature_encoders_core.sv
// Scans a matrix of rotary encoders: each accepted row sample belongs to the next column and
// yields one result per row group (A, B, button), the last one marked. A scan tick is issued
// one row group at a time while the output queue has room, set by the single read port of the
// count memory, which is read once per group and written back on the next cycle; ticks may
// follow each other with no gap. The sample is registered, its counts are read in stage one,
// updated in stage two and written into the output queue. Counts and stored row levels live
// in small rams whose entries read as zero until first written, so no clearing pass is needed
// after reset. A two-entry output queue keeps results moving while the sink stalls.
// depends on msqe_pkg, msqe_stream_if, msqe_ram and the macros header
`include "matrix_scanned_quadrature_encoders_core_macros.svh"

module matrix_scanned_quadrature_encoders_core (
  input  logic                 clk,
  input  logic                 rst,
  msqe_item_if.sink            items,
  msqe_result_if.source        results
);

  localparam logic [msqe_pkg::GRP_BITS-1:0] GRP_LAST =
    msqe_pkg::GRP_BITS'(msqe_pkg::GROUPS - 1);
  localparam logic [msqe_pkg::COL_BITS-1:0] COL_LAST =
    msqe_pkg::COL_BITS'(msqe_pkg::COLUMNS - 1);

  // item register and sequencer
  logic                              busy;
  logic [msqe_pkg::GRP_BITS-1:0]     grp;
  logic [msqe_pkg::COL_BITS-1:0]     cur_col;
  logic [msqe_pkg::ROWS-1:0]         lv;
  logic [msqe_pkg::COL_BITS-1:0]     col_next;
  logic                              issue;
  logic                              in_xfer;
  logic                              pop;

  // stage two
  logic                              s2_valid;
  logic [msqe_pkg::GRP_BITS-1:0]     s2_grp;
  logic [msqe_pkg::COL_BITS-1:0]     s2_col;
  logic [msqe_pkg::ENC_BITS-1:0]     s2_addr;
  logic                              s2_a;
  logic                              s2_b;
  logic                              s2_btn;
  logic                              s2_last;
  logic [msqe_pkg::ROWS-1:0]         s2_now;

  // memories and forwarding
  logic [msqe_pkg::ENC_BITS-1:0]     cnt_raddr;
  logic [msqe_pkg::COUNT_BITS-1:0]   cnt_rdata;
  logic [msqe_pkg::COUNT_BITS-1:0]   cnt_old;
  logic [msqe_pkg::COUNT_BITS-1:0]   cnt_new;
  logic [msqe_pkg::ROWS-1:0]         prev_rdata;
  logic [msqe_pkg::ROWS-1:0]         prev_old;
  logic [msqe_pkg::ROWS-1:0]         prev_sh;
  logic [msqe_pkg::ROWS-1:0]         now_sh;
  logic [msqe_pkg::ENCODERS-1:0]     cnt_vld;
  logic [msqe_pkg::COLUMNS-1:0]      prev_vld;
  logic                              fwd_cnt_vld;
  logic [msqe_pkg::ENC_BITS-1:0]     fwd_cnt_addr;
  logic [msqe_pkg::COUNT_BITS-1:0]   fwd_cnt_data;
  logic                              fwd_prev_vld;
  logic [msqe_pkg::COL_BITS-1:0]     fwd_prev_addr;
  logic [msqe_pkg::ROWS-1:0]         fwd_prev_data;
  logic                              prev_we;
  logic                              a_fell;
  logic                              b_fell;

  // output queue
  msqe_pkg::result_t                 fifo_mem [msqe_pkg::FIFO_DEPTH];
  msqe_pkg::result_t                 res;
  msqe_pkg::result_t                 head;
  logic                              wptr;
  logic                              rptr;
  logic [1:0]                        fifo_cnt;

  assign pop     = results.valid && results.ready;
  assign in_xfer = items.valid && items.ready;
  assign issue   = busy &&
                   ((fifo_cnt + 2'(s2_valid)) < (2'(msqe_pkg::FIFO_DEPTH) + 2'(pop)));
  assign items.ready = !busy || (issue && grp == GRP_LAST);
  assign col_next = (cur_col == COL_LAST) ? '0 : cur_col + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      grp     <= '0;
      cur_col <= COL_LAST;
    end else begin
      if (issue) begin
        if (grp == GRP_LAST) begin
          grp <= '0;
        end else begin
          grp <= grp + 1'b1;
        end
      end
      if (in_xfer) begin
        busy    <= 1'b1;
        cur_col <= col_next;
      end else if (issue && grp == GRP_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lv <= items.row_levels[msqe_pkg::ROWS-1:0];
    end
  end

  // stage one: read count and stored levels
  assign cnt_raddr = msqe_pkg::ENC_BITS'(int'(grp) * msqe_pkg::COLUMNS + int'(cur_col));
  assign now_sh    = lv >> (int'(grp) * msqe_pkg::ROWS_PER_GROUP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    s2_grp  <= grp;
    s2_col  <= cur_col;
    s2_addr <= cnt_raddr;
    s2_a    <= now_sh[0];
    s2_b    <= now_sh[1];
    s2_btn  <= now_sh[2];
    s2_last <= (grp == GRP_LAST);
    s2_now  <= lv;
  end

  msqe_ram #(
    .WIDTH (msqe_pkg::COUNT_BITS),
    .DEPTH (msqe_pkg::ENCODERS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (s2_valid),
    .waddr (s2_addr),
    .wdata (cnt_new),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  msqe_ram #(
    .WIDTH (msqe_pkg::ROWS),
    .DEPTH (msqe_pkg::COLUMNS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (s2_col),
    .wdata (s2_now),
    .raddr (cur_col),
    .rdata (prev_rdata)
  );

  // stage two: modify and write back
  assign prev_we = s2_valid && s2_last;

  always_comb begin
    if (fwd_cnt_vld && fwd_cnt_addr == s2_addr) begin
      cnt_old = fwd_cnt_data;
    end else if (cnt_vld[s2_addr]) begin
      cnt_old = cnt_rdata;
    end else begin
      cnt_old = '0;
    end
    if (fwd_prev_vld && fwd_prev_addr == s2_col) begin
      prev_old = fwd_prev_data;
    end else if (prev_vld[s2_col]) begin
      prev_old = prev_rdata;
    end else begin
      prev_old = '0;
    end
    prev_sh = prev_old >> (int'(s2_grp) * msqe_pkg::ROWS_PER_GROUP);
    a_fell  = prev_sh[0] && !s2_a;
    b_fell  = prev_sh[1] && !s2_b;
    if (a_fell && s2_b) begin
      cnt_new = cnt_old + 1'b1;
    end else if (b_fell && s2_a) begin
      cnt_new = cnt_old - 1'b1;
    end else begin
      cnt_new = cnt_old;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld      <= '0;
      prev_vld     <= '0;
      fwd_cnt_vld  <= 1'b0;
      fwd_prev_vld <= 1'b0;
    end else begin
      fwd_cnt_vld  <= s2_valid;
      fwd_prev_vld <= prev_we;
      if (s2_valid) begin
        cnt_vld[s2_addr] <= 1'b1;
      end
      if (prev_we) begin
        prev_vld[s2_col] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_cnt_addr  <= s2_addr;
    fwd_cnt_data  <= cnt_new;
    fwd_prev_addr <= s2_col;
    fwd_prev_data <= s2_now;
  end

  // output queue
  always_comb begin
    res.column        = msqe_pkg::COLUMN_FIELD_BITS'(s2_col);
    res.encoder_index = msqe_pkg::INDEX_FIELD_BITS'(s2_addr);
    res.count         = msqe_pkg::COUNT_FIELD_BITS'(cnt_new);
    res.pressed       = !s2_btn;
    res.last          = s2_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr     <= 1'b0;
      rptr     <= 1'b0;
      fifo_cnt <= '0;
    end else begin
      if (s2_valid) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      fifo_cnt <= fifo_cnt + 2'(s2_valid) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      fifo_mem[wptr] <= res;
    end
  end

  assign head                  = fifo_mem[rptr];
  assign results.valid         = (fifo_cnt != '0);
  assign results.column        = head.column;
  assign results.encoder_index = head.encoder_index;
  assign results.count         = head.count;
  assign results.pressed       = head.pressed;
  assign results.last          = head.last;

  `MSQE_ASSERT(a_fifo_bound, fifo_cnt <= 2'(msqe_pkg::FIFO_DEPTH))
  `MSQE_ASSERT(a_push_room, s2_valid |-> fifo_cnt < 2'(msqe_pkg::FIFO_DEPTH))
  `MSQE_ASSERT(a_accept_starts, in_xfer |=> busy && grp == '0)
  `MSQE_ASSERT_RST(a_reset_idle, rst |=> !busy && !s2_valid && fifo_cnt == '0)

endmodule

// File: test/msqe_scan_checker.sv
// scoreboard for the matrix scanned quadrature encoder core: predicts results from
// accepted row samples and compares them with accepted results
// depends on msqe_pkg and msqe_stream_if
`timescale 1ns / 100ps

module msqe_scan_checker (
  input  logic   clk,
  input  logic   rst,
  msqe_item_if   items,
  msqe_result_if results,
  output int     failures,
  output int     outstanding
);

  int                               scan_column;
  logic [msqe_pkg::ROWS-1:0]        stored_rows [msqe_pkg::COLUMNS];
  logic [msqe_pkg::COUNT_BITS-1:0]  encoder_count [msqe_pkg::ENCODERS];
  msqe_pkg::result_t                expected_results [$];
  int                               failures_seen;

  task automatic note_failure(string msg);
    failures_seen++;
    if (failures_seen <= 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(string field, int exp_v, int act_v);
    if (exp_v != act_v) begin
      note_failure($sformatf("%s expected %0d, got %0d", field, exp_v, act_v));
    end
  endtask

  // one scan tick: next column, edge detect per row group, one result per group
  task automatic predict_scan(input logic [msqe_pkg::ROWS-1:0] levels);
    logic [msqe_pkg::ROWS-1:0] prev;
    logic                      a_now;
    logic                      b_now;
    logic                      a_fell;
    logic                      b_fell;
    int                        e;
    msqe_pkg::result_t         r;
    scan_column = (scan_column + 1 >= msqe_pkg::COLUMNS) ? 0 : scan_column + 1;
    prev = stored_rows[scan_column];
    for (int g = 0; g < msqe_pkg::GROUPS; g++) begin
      a_now  = levels[g*msqe_pkg::ROWS_PER_GROUP];
      b_now  = levels[g*msqe_pkg::ROWS_PER_GROUP+1];
      a_fell = prev[g*msqe_pkg::ROWS_PER_GROUP] && !a_now;
      b_fell = prev[g*msqe_pkg::ROWS_PER_GROUP+1] && !b_now;
      e = g * msqe_pkg::COLUMNS + scan_column;
      if (b_fell && a_now) begin
        encoder_count[e] = encoder_count[e] - 1'b1;
      end
      if (a_fell && b_now) begin
        encoder_count[e] = encoder_count[e] + 1'b1;
      end
      r.column        = msqe_pkg::COLUMN_FIELD_BITS'(scan_column);
      r.encoder_index = msqe_pkg::INDEX_FIELD_BITS'(e);
      r.count         = msqe_pkg::COUNT_FIELD_BITS'(encoder_count[e]);
      r.pressed       = !levels[g*msqe_pkg::ROWS_PER_GROUP+2];
      r.last          = (g == msqe_pkg::GROUPS - 1);
      expected_results.push_back(r);
    end
    stored_rows[scan_column] = levels;
  endtask

  initial begin
    failures_seen = 0;
  end

  always @(posedge clk) begin
    msqe_pkg::result_t want;
    if (rst) begin
      scan_column = msqe_pkg::COLUMNS - 1;
      for (int c = 0; c < msqe_pkg::COLUMNS; c++) stored_rows[c] = '0;
      for (int e = 0; e < msqe_pkg::ENCODERS; e++) encoder_count[e] = '0;
      expected_results.delete();
    end else begin
      if (items.valid && items.ready) begin
        predict_scan(items.row_levels);
      end
      if (results.valid && results.ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result for encoder %0d", results.encoder_index));
        end else begin
          want = expected_results.pop_front();
          check_field("column", int'(want.column), int'(results.column));
          check_field("encoder_index", int'(want.encoder_index),
                      int'(results.encoder_index));
          check_field("count", int'(want.count), int'(results.count));
          check_field("pressed", int'(want.pressed), int'(results.pressed));
          check_field("last", int'(want.last), int'(results.last));
        end
      end
    end
    failures    <= failures_seen;
    outstanding <= expected_results.size();
  end

endmodule

// File: test/matrix_scanned_quadrature_encoders_core_test.sv
// top of the encoder matrix core test: clock, reset, row sample stimulus with bursts
// and gaps, result back-pressure and the verdict
// depends on msqe_pkg, msqe_stream_if, the core and msqe_scan_checker
`timescale 1ns / 100ps

module matrix_scanned_quadrature_encoders_core_test;

  typedef enum int {RX_FLOW, RX_RANDOM, RX_CHOKE} rx_mode_e;

  localparam int RANDOM_SCANS = 500;

  logic clk;
  logic rst;
  int   failures;
  int   outstanding;
  int   burst_left;
  int   col_cursor;
  logic [msqe_pkg::ROWS-1:0] sent_rows [msqe_pkg::COLUMNS];

  msqe_item_if   items_ch ();
  msqe_result_if results_ch ();

  matrix_scanned_quadrature_encoders_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  msqe_scan_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .items       (items_ch),
    .results     (results_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("matrix_scanned_quadrature_encoders_core test failed");
    $finish;
  end

  // sink back-pressure in segments of free flow, random stalls and heavy stalls
  initial begin
    rx_mode_e mode;
    int       seg_len;
    results_ch.ready = 1'b0;
    forever begin
      mode    = rx_mode_e'($urandom_range(0, 2));
      seg_len = $urandom_range(4, 40);
      repeat (seg_len) begin
        @(negedge clk);
        case (mode)
          RX_FLOW:   results_ch.ready = 1'b1;
          RX_RANDOM: results_ch.ready = 1'($urandom_range(0, 1));
          default:   results_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_scan(input logic [msqe_pkg::ROWS-1:0] levels);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        items_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    items_ch.valid      = 1'b1;
    items_ch.row_levels = levels;
    do @(posedge clk); while (!items_ch.ready);
    burst_left--;
    sent_rows[col_cursor] = levels;
    col_cursor = (col_cursor + 1) % msqe_pkg::COLUMNS;
  endtask

  // one quadrature step per encoder at most, buttons mostly released
  function automatic logic [msqe_pkg::ROWS-1:0] next_quadrature(
    input logic [msqe_pkg::ROWS-1:0] prev
  );
    logic [msqe_pkg::ROWS-1:0] levels;
    levels = prev;
    for (int g = 0; g < msqe_pkg::GROUPS; g++) begin
      case ($urandom_range(0, 4))
        1, 2:    levels[g*msqe_pkg::ROWS_PER_GROUP]   = ~levels[g*msqe_pkg::ROWS_PER_GROUP];
        3, 4:    levels[g*msqe_pkg::ROWS_PER_GROUP+1] = ~levels[g*msqe_pkg::ROWS_PER_GROUP+1];
        default: ;
      endcase
      levels[g*msqe_pkg::ROWS_PER_GROUP+2] = ($urandom_range(0, 3) != 0);
    end
    return levels;
  endfunction

  initial begin
    logic [msqe_pkg::ROWS-1:0] directed [20];
    directed = '{
      // first visits: no edges possible
      6'h3F, 6'h00, 6'h3F, 6'h15,
      // A falls with B high, no change, B falls with A high, nothing useful falls
      6'h36, 6'h3F, 6'h2D, 6'h00,
      // rises, both phases fall together, rises
      6'h3F, 6'h24, 6'h3F, 6'h3F,
      // count back to zero, count below zero, mixed up and down with a press
      6'h2D, 6'h3F, 6'h2D, 6'h2A,
      // all buttons pressed, then released
      6'h00, 6'h00, 6'h3F, 6'h3F
    };
    rst                 = 1'b1;
    items_ch.valid      = 1'b0;
    items_ch.row_levels = '0;
    burst_left          = 0;
    col_cursor          = 0;
    for (int c = 0; c < msqe_pkg::COLUMNS; c++) sent_rows[c] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_scan(directed[i]);
    repeat (RANDOM_SCANS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_scan(msqe_pkg::ROWS'($urandom_range(0, (1 << msqe_pkg::ROWS) - 1)));
      end else begin
        send_scan(next_quadrature(sent_rows[col_cursor]));
      end
    end
    @(negedge clk);
    items_ch.valid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("matrix_scanned_quadrature_encoders_core test passed");
    end else begin
      $display("matrix_scanned_quadrature_encoders_core test failed");
    end
    $finish;
  end

endmodule
